@@ rtl/tcp_stream_reassembler_top_macros.svh @@
// ----------------------------------------------------------------------------
// tcp stream reassembler assertion macros
// shared concurrent assertion forms, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef TCP_STREAM_REASSEMBLER_TOP_MACROS_SVH
`define TCP_STREAM_REASSEMBLER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define TSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tsr assertion failed");
`define TSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tsr assertion failed");
`else
`define TSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/tsr_pkg.sv @@
// ----------------------------------------------------------------------------
// tsr_pkg
// types and constants shared by the stream reassembler modules
// ----------------------------------------------------------------------------
package tsr_pkg;

	localparam int IDX_W   = 64;
	localparam int BYTE_W  = 8;
	localparam int CAP_W   = 13;
	localparam int IN_W    = 72;
	localparam int OUT_W   = 88;
	localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

	typedef enum logic [1:0] {
		MODE_DATA = 2'd0,
		MODE_END  = 2'd1,
		MODE_POP  = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic vld_we;
		logic vld_wbit;
		logic byte_we;
	} mem_ctl_t;

endpackage

@@ rtl/tsr_alu.sv @@
// ----------------------------------------------------------------------------
// tsr_alu
// shared 64-bit add / subtract unit with borrow out
// ----------------------------------------------------------------------------
module tsr_alu import tsr_pkg::*; (
	input  logic [IDX_W-1:0] a,
	input  logic [IDX_W-1:0] b,
	input  alu_op_t          op,
	output logic [IDX_W-1:0] y,
	output logic             borrow
);

	logic [IDX_W:0] sum;

	always_comb begin
		if (op == ALU_SUB) begin
			sum = {1'b0, a} - {1'b0, b};
		end else begin
			sum = {1'b0, a} + {1'b0, b};
		end
	end

	assign y      = sum[IDX_W-1:0];
	assign borrow = sum[IDX_W];

endmodule

@@ rtl/tsr_ring.sv @@
// ----------------------------------------------------------------------------
// tsr_ring
// byte ring and per-slot valid marks, registered reads
// ----------------------------------------------------------------------------
module tsr_ring import tsr_pkg::*; #(
	parameter int DEPTH = 4096,
	parameter int SW    = 12
) (
	input  logic              clk,
	input  mem_ctl_t          ctl,
	input  logic [SW-1:0]     vld_waddr,
	input  logic [SW-1:0]     vld_raddr,
	input  logic [SW-1:0]     byte_waddr,
	input  logic [SW-1:0]     byte_raddr,
	input  logic [BYTE_W-1:0] byte_wdata,
	output logic              vld_rdata,
	output logic [BYTE_W-1:0] byte_rdata
);

	logic              vld_mem [DEPTH];
	logic [BYTE_W-1:0] byte_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.vld_we) begin
			vld_mem[vld_waddr] <= ctl.vld_wbit;
		end
		vld_rdata <= vld_mem[vld_raddr];
	end

	always_ff @(posedge clk) begin
		if (ctl.byte_we) begin
			byte_mem[byte_waddr] <= byte_wdata;
		end
		byte_rdata <= byte_mem[byte_raddr];
	end

endmodule

@@ rtl/tcp_stream_reassembler_top.sv @@
// ----------------------------------------------------------------------------
// tcp_stream_reassembler_top
// out-of-order byte stream reassembler with a shared ring for reader output
// ----------------------------------------------------------------------------
// One request is handled at a time by a small sequencer around one shared
// 64-bit add/subtract unit and a single-port-per-side ring memory. After reset
// the valid marks are cleared by a sweep over every ring slot, during which no
// request is taken (capacity writes still are). An end mark or unused mode
// goes straight to the done state; a pop reads the ring first unless nothing
// is assembled; a data byte computes its offset and distances and is then
// dropped, or written, marked and followed by the frontier walk, which reads
// one valid mark per cycle. A finished result sits in the output register while
// the next request is taken; while that register stays full when the next
// result is ready, the sequencer waits in its done state.
module tcp_stream_reassembler_top import tsr_pkg::*; #(
	parameter int RING_DEPTH = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // stream_index[63:0], data_byte[71:64]
	input  logic [1:0]       s_tuser,   // mode[1:0]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // byte_accepted[0], read_valid[1], read_byte[9:2],
	                                    // assembled_count[73:10], pending_count[86:74],
	                                    // stream_closed[87]
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata
);

	`include "tcp_stream_reassembler_top_macros.svh"

	localparam int SW   = $clog2(RING_DEPTH);
	localparam int CW   = SW + 1;
	localparam int CAPW = (CW > CAP_W) ? CW : CAP_W;
	localparam logic [SW-1:0]   SLOT_LAST = SW'(RING_DEPTH - 1);
	localparam logic [CW-1:0]   DEPTH_CW  = CW'(RING_DEPTH);
	localparam logic [CAPW-1:0] DEPTH_CAP = CAPW'(RING_DEPTH);

	typedef enum logic [12:0] {
		ST_CLEAR    = 13'b0000000000001,
		ST_IDLE     = 13'b0000000000010,
		ST_OFF      = 13'b0000000000100,
		ST_D1       = 13'b0000000001000,
		ST_D2       = 13'b0000000010000,
		ST_CMP      = 13'b0000000100000,
		ST_WR       = 13'b0000001000000,
		ST_MARK     = 13'b0000010000000,
		ST_ADV_RD   = 13'b0000100000000,
		ST_ADV_CHK  = 13'b0001000000000,
		ST_POP_RD   = 13'b0010000000000,
		ST_POP_DATA = 13'b0100000000000,
		ST_DONE     = 13'b1000000000000
	} state_t;

	state_t              state_q;
	logic [SW-1:0]       clr_q;
	mode_t               in_mode;
	logic [IDX_W-1:0]    in_idx;
	logic [IDX_W-1:0]    idx_q;
	logic [BYTE_W-1:0]   dbyte_q;
	logic [CAP_W-1:0]    wcap_q;
	logic [IDX_W-1:0]    frontier_q;
	logic [IDX_W-1:0]    read_q;
	logic [IDX_W-1:0]    end_q;
	logic                end_known_q;
	logic                closed_q;
	logic [CW-1:0]       lead_q;
	logic [CW-1:0]       pend_q;
	logic [SW-1:0]       rd_slot_q;
	logic [SW-1:0]       fr_slot_q;
	logic [IDX_W-1:0]    off_q;
	logic [IDX_W-1:0]    d1_q;
	logic [IDX_W-1:0]    d2_q;
	logic                win_bad_q;
	logic [SW-1:0]       slot_q;
	logic                acc_q;
	logic                rvalid_q;
	logic [BYTE_W-1:0]   rbyte_q;
	logic                m_tvalid_q;
	logic [OUT_W-1:0]    m_tdata_q;

	logic [IDX_W-1:0]    alu_a;
	logic [IDX_W-1:0]    alu_b;
	alu_op_t             alu_op;
	logic [IDX_W-1:0]    alu_y;
	logic                alu_borrow;

	mem_ctl_t            mem_ctl;
	logic [SW-1:0]       vld_waddr;
	logic [SW-1:0]       vld_raddr;
	logic                vld_rdata;
	logic [BYTE_W-1:0]   byte_rdata;

	logic [CAPW-1:0]     cap;
	logic                off_lt_lead;
	logic                off_ge_cap;
	logic [CW-1:0]       slot_sum;
	logic [SW-1:0]       slot_new;
	logic [SW-1:0]       fr_slot_inc;
	logic [SW-1:0]       rd_slot_inc;
	logic                adv_go;
	logic                close_hit;
	logic                out_fire;
	logic                closed_nx;
	logic [CW:0]         stored_cnt;

	function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
		logic [SW-1:0] r;
		r = (s == SLOT_LAST) ? '0 : s + 1'b1;
		return r;
	endfunction

	assign in_mode = mode_t'(s_tuser);
	assign in_idx  = s_tdata[IDX_W-1:0];

	// window checks against the offset from the reader
	assign cap = (CAPW'(wcap_q) < DEPTH_CAP) ? CAPW'(wcap_q) : DEPTH_CAP;
	assign off_lt_lead = (off_q[IDX_W-1:CW] == '0) && (off_q[CW-1:0] < lead_q);
	assign off_ge_cap  = (off_q[IDX_W-1:CAPW] != '0) || (off_q[CAPW-1:0] >= cap);
	assign slot_sum = CW'(rd_slot_q) + off_q[CW-1:0];
	assign slot_new = (slot_sum >= DEPTH_CW) ? SW'(slot_sum - DEPTH_CW) : SW'(slot_sum);

	assign fr_slot_inc = slot_inc(fr_slot_q);
	assign rd_slot_inc = slot_inc(rd_slot_q);
	assign adv_go = (lead_q < DEPTH_CW) && vld_rdata && (pend_q != '0);

	assign close_hit = end_known_q && (alu_y == '0);
	assign out_fire  = !m_tvalid_q || m_tready;
	assign closed_nx = closed_q || close_hit;
	assign stored_cnt = (CW+1)'(lead_q) + (CW+1)'(pend_q);

	// shared unit operand selection
	always_comb begin
		alu_a  = frontier_q;
		alu_b  = end_q;
		alu_op = ALU_SUB;
		unique case (state_q)
			ST_OFF: begin
				alu_a = idx_q;
				alu_b = read_q;
			end
			ST_D1: begin
				alu_a = idx_q;
				alu_b = frontier_q;
			end
			ST_D2: begin
				alu_a = end_q;
				alu_b = frontier_q;
			end
			ST_CMP: begin
				alu_a = d1_q;
				alu_b = d2_q;
			end
			ST_ADV_CHK: begin
				alu_b  = IDX_W'(1);
				alu_op = ALU_ADD;
			end
			ST_POP_DATA: begin
				alu_a  = read_q;
				alu_b  = IDX_W'(1);
				alu_op = ALU_ADD;
			end
			default: begin
				alu_a = frontier_q;
			end
		endcase
	end

	tsr_alu u_alu (
		.a      (alu_a),
		.b      (alu_b),
		.op     (alu_op),
		.y      (alu_y),
		.borrow (alu_borrow)
	);

	// ring access control
	always_comb begin
		mem_ctl   = '0;
		vld_waddr = slot_q;
		vld_raddr = fr_slot_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_ctl.vld_we = 1'b1;
				vld_waddr      = clr_q;
			end
			ST_WR: begin
				mem_ctl.byte_we = 1'b1;
				vld_raddr       = slot_q;
			end
			ST_MARK: begin
				mem_ctl.vld_we   = 1'b1;
				mem_ctl.vld_wbit = 1'b1;
			end
			ST_ADV_CHK: begin
				vld_raddr = adv_go ? fr_slot_inc : fr_slot_q;
			end
			ST_POP_DATA: begin
				mem_ctl.vld_we = 1'b1;
				vld_waddr      = rd_slot_q;
			end
			default: begin
				vld_raddr = fr_slot_q;
			end
		endcase
	end

	tsr_ring #(
		.DEPTH (RING_DEPTH),
		.SW    (SW)
	) u_ring (
		.clk        (clk),
		.ctl        (mem_ctl),
		.vld_waddr  (vld_waddr),
		.vld_raddr  (vld_raddr),
		.byte_waddr (slot_q),
		.byte_raddr (rd_slot_q),
		.byte_wdata (dbyte_q),
		.vld_rdata  (vld_rdata),
		.byte_rdata (byte_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcap_q <= CAP_RESET;
		end else if (cfg_we) begin
			wcap_q <= cfg_wdata;
		end
	end

	// sequencer and stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			frontier_q  <= '0;
			read_q      <= '0;
			end_q       <= '0;
			end_known_q <= 1'b0;
			closed_q    <= 1'b0;
			lead_q      <= '0;
			pend_q      <= '0;
			rd_slot_q   <= '0;
			fr_slot_q   <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= slot_inc(clr_q);
					if (clr_q == SLOT_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						unique case (in_mode)
							MODE_DATA: begin
								state_q <= ST_OFF;
							end
							MODE_END: begin
								if (!closed_q) begin
									end_q       <= in_idx;
									end_known_q <= 1'b1;
								end
								state_q <= ST_DONE;
							end
							MODE_POP: begin
								state_q <= (lead_q != '0) ? ST_POP_RD : ST_DONE;
							end
							MODE_NONE: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_OFF: begin
					state_q <= ST_D1;
				end
				ST_D1: begin
					state_q <= ST_D2;
				end
				ST_D2: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (closed_q || win_bad_q || (end_known_q && !alu_borrow)) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					state_q <= ST_MARK;
				end
				ST_MARK: begin
					if (!vld_rdata) begin
						pend_q <= pend_q + 1'b1;
					end
					state_q <= ST_ADV_RD;
				end
				ST_ADV_RD: begin
					state_q <= ST_ADV_CHK;
				end
				ST_ADV_CHK: begin
					if (adv_go) begin
						frontier_q <= alu_y;
						fr_slot_q  <= fr_slot_inc;
						lead_q     <= lead_q + 1'b1;
						pend_q     <= pend_q - 1'b1;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_POP_RD: begin
					state_q <= ST_POP_DATA;
				end
				ST_POP_DATA: begin
					read_q    <= alu_y;
					rd_slot_q <= rd_slot_inc;
					lead_q    <= lead_q - 1'b1;
					state_q   <= ST_DONE;
				end
				ST_DONE: begin
					if (out_fire) begin
						closed_q   <= closed_nx;
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request payload and per-request scratch
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				idx_q    <= in_idx;
				dbyte_q  <= s_tdata[IN_W-1:IDX_W];
				acc_q    <= 1'b0;
				rvalid_q <= 1'b0;
				rbyte_q  <= '0;
			end
			ST_OFF: begin
				off_q <= alu_y;
			end
			ST_D1: begin
				d1_q      <= alu_y;
				win_bad_q <= off_lt_lead || off_ge_cap;
				slot_q    <= slot_new;
			end
			ST_D2: begin
				d2_q <= alu_y;
			end
			ST_WR: begin
				acc_q <= 1'b1;
			end
			ST_POP_DATA: begin
				rvalid_q <= 1'b1;
				rbyte_q  <= byte_rdata;
			end
			ST_DONE: begin
				if (out_fire) begin
					m_tdata_q <= {closed_nx, CAP_W'(pend_q), frontier_q, rbyte_q, rvalid_q, acc_q};
				end
			end
			default: begin
			end
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`TSR_ASSERT_IMP(a_lead_bound, clk, arst_n, 1'b1, lead_q <= DEPTH_CW)
	`TSR_ASSERT_IMP(a_store_fits, clk, arst_n, 1'b1, stored_cnt <= (CW+1)'(RING_DEPTH))
	`TSR_ASSERT_NXT(a_closed_sticky, clk, arst_n, closed_q, closed_q)
	`TSR_ASSERT_IMP(a_pop_has_data, clk, arst_n, state_q == ST_POP_RD, lead_q != '0)
	`TSR_ASSERT_NXT(a_adv_step, clk, arst_n, state_q == ST_ADV_CHK && adv_go,
		frontier_q == $past(frontier_q) + 64'd1)

endmodule
